/* hw/rtl/lzwd_pkg.sv */
// Shared types and constants for the LZSS window decoder.
// Depends on nothing; the controller, datapath and top level refer to it by scoped names.
`timescale 1ns / 1ps

package lzwd_pkg;

    localparam int BYTE_W    = 8;
    localparam int CNT_W     = 24;
    localparam int WIN_DEPTH = 4096;
    localparam int POS_W     = $clog2(WIN_DEPTH);
    localparam int FILL_W    = POS_W + 1;
    localparam int MAX_RUN   = 18;
    localparam int RUN_W     = $clog2(MAX_RUN + 1);

    localparam logic [POS_W-1:0]  WRITE_START = 12'hFEE;
    localparam logic [BYTE_W-1:0] FILL_BYTE   = 8'hFF;
    localparam logic [BYTE_W-1:0] FLAG_MARK   = 8'hFF;
    localparam logic [RUN_W-1:0]  RUN_BIAS    = 5'd3;

    // Payload of one compressed input request
    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              first_of_stream;
        logic              last_input;
    } t_in_data;

    // Payload of one decompressed output request
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_run;
        logic              stream_done;
    } t_out_data;

    // Payload of one configuration write
    typedef struct packed {
        logic [CNT_W-1:0] output_length;
    } t_cfg_data;

    // Controller to datapath
    typedef struct packed {
        logic take_ok;
        logic emit;
        logic issue_read;
        logic last_of_run;
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic             a_vld;
        logic             out_free;
        logic             hit;
        logic             start_copy;
        logic [RUN_W-1:0] copy_len;
    } t_dp_status;

endpackage

/* hw/rtl/lzwd_stream_if.sv */
// Valid/ready channel carrying one payload of a chosen packed type.
// Payload types come from lzwd_pkg.
`timescale 1ns / 1ps

interface lzwd_stream_if #(
    parameter type t_data = logic
) ();
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/lzwd_ctrl.sv */
// Controller for the LZSS window decoder: sequences copy runs and emits.
// Depends on lzwd_pkg for the command and status structs.
`timescale 1ns / 1ps

module lzwd_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lzwd_pkg::t_dp_status   i_status,
    output lzwd_pkg::t_ctrl_cmd    o_cmd
);

    localparam logic [0:0] S_IDLE = 1'b0;
    localparam logic [0:0] S_RUN  = 1'b1;

    logic [0:0]                 r_state;
    logic [0:0]                 n_state;
    logic [lzwd_pkg::RUN_W-1:0] r_emit_left;
    logic [lzwd_pkg::RUN_W-1:0] n_emit_left;
    logic [lzwd_pkg::RUN_W-1:0] r_read_left;
    logic [lzwd_pkg::RUN_W-1:0] n_read_left;
    logic                       emit;
    logic                       lor;
    logic                       issue;

    // Move the staged byte out whenever the output register frees up; mark run ends and issue window reads
    always_comb begin
        emit  = i_status.a_vld && i_status.out_free;
        lor   = (r_state == S_IDLE) || (r_emit_left == lzwd_pkg::RUN_W'(1)) || i_status.hit;
        issue = (r_state == S_RUN) && (r_read_left != '0)
                && (!i_status.a_vld || emit) && !(emit && i_status.hit);
    end

    // Next state and run counters
    always_comb begin
        n_state     = r_state;
        n_emit_left = r_emit_left;
        n_read_left = r_read_left;
        unique case (r_state)
            S_IDLE: begin
                if (i_status.start_copy) begin
                    n_state     = S_RUN;
                    n_emit_left = i_status.copy_len;
                    n_read_left = i_status.copy_len;
                end
            end
            S_RUN: begin
                if (emit) begin
                    n_emit_left = r_emit_left - lzwd_pkg::RUN_W'(1);
                end
                if (issue) begin
                    n_read_left = r_read_left - lzwd_pkg::RUN_W'(1);
                end
                // drop the rest of the run on its final byte or at the limit
                if (emit && lor) begin
                    n_state     = S_IDLE;
                    n_emit_left = '0;
                    n_read_left = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_emit_left <= '0;
            r_read_left <= '0;
        end else begin
            r_state     <= n_state;
            r_emit_left <= n_emit_left;
            r_read_left <= n_read_left;
        end
    end

    assign o_cmd = '{
        take_ok:     (r_state == S_IDLE),
        emit:        emit,
        issue_read:  issue,
        last_of_run: lor
    };

endmodule

/* hw/rtl/lzwd_datapath.sv */
// Datapath for the LZSS window decoder: command decode, ring window,
// staging byte and output register. Depends on lzwd_pkg and lzwd_stream_if.
`timescale 1ns / 1ps

module lzwd_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    lzwd_stream_if.sink          i_in,
    lzwd_stream_if.source        o_out,
    lzwd_stream_if.sink          i_cfg,
    input  lzwd_pkg::t_ctrl_cmd  i_cmd,
    output lzwd_pkg::t_dp_status o_status
);

    // Decoder phase codes
    localparam logic [1:0] PH_CMD    = 2'd0;
    localparam logic [1:0] PH_LIT    = 2'd1;
    localparam logic [1:0] PH_POS_LO = 2'd2;
    localparam logic [1:0] PH_POS_HI = 2'd3;

    logic [lzwd_pkg::BYTE_W-1:0] r_window [lzwd_pkg::WIN_DEPTH];

    logic [lzwd_pkg::POS_W-1:0]  r_wr_pos;
    logic [lzwd_pkg::FILL_W-1:0] r_fill;
    logic [lzwd_pkg::CNT_W-1:0]  r_bytes;
    logic [lzwd_pkg::CNT_W-1:0]  r_limit;
    logic [15:0]                 r_flags;
    logic [1:0]                  r_phase;
    logic [lzwd_pkg::BYTE_W-1:0] r_pos_lo;
    logic                        r_finished;
    logic                        r_item_last;
    logic [lzwd_pkg::POS_W-1:0]  r_rd_pos;
    logic                        r_a_vld;
    logic [lzwd_pkg::BYTE_W-1:0] r_a_byte;
    logic                        r_out_vld;
    lzwd_pkg::t_out_data         r_out;

    logic                        in_acc;
    logic [lzwd_pkg::BYTE_W-1:0] in_byte;
    logic [1:0]                  base_phase;
    logic [15:0]                 base_flags;
    logic [lzwd_pkg::CNT_W-1:0]  base_bytes;
    logic                        base_fin;
    logic                        ignore;
    logic [15:0]                 flags_sh;
    logic [15:0]                 flags_d;
    logic [1:0]                  phase_d;
    logic                        dec_lit;
    logic                        dec_copy;
    logic                        pos_load;
    logic                        take_lit;
    logic                        take_copy;
    logic                        take_pos;
    logic [lzwd_pkg::CNT_W-1:0]  bytes_inc;
    logic                        hit;
    logic [lzwd_pkg::POS_W-1:0]  rd_offset;
    logic                        rd_written;
    logic                        rd_bypass;

    assign in_acc  = i_in.valid && i_in.ready;
    assign in_byte = i_in.data.in_byte;

    // Decoder state as seen by this request, after an optional restart
    always_comb begin
        base_phase = i_in.data.first_of_stream ? PH_CMD : r_phase;
        base_flags = i_in.data.first_of_stream ? 16'h0000 : r_flags;
        base_bytes = i_in.data.first_of_stream ? '0 : r_bytes;
        base_fin   = i_in.data.first_of_stream ? 1'b0 : r_finished;
        ignore     = base_fin || ((r_limit != '0) && (base_bytes >= r_limit));
        flags_sh   = {1'b0, base_flags[15:1]};
    end

    // Decode the byte against the current phase and flag bits
    always_comb begin
        flags_d  = base_flags;
        phase_d  = base_phase;
        dec_lit  = 1'b0;
        dec_copy = 1'b0;
        pos_load = 1'b0;
        unique case (base_phase)
            PH_CMD: begin
                flags_d = flags_sh;
                if (!flags_sh[8]) begin
                    // flag bits exhausted: this byte is a new flag byte
                    flags_d = {lzwd_pkg::FLAG_MARK, in_byte};
                    phase_d = in_byte[0] ? PH_LIT : PH_POS_LO;
                end else if (flags_sh[0]) begin
                    dec_lit = 1'b1;
                end else begin
                    pos_load = 1'b1;
                    phase_d  = PH_POS_HI;
                end
            end
            PH_LIT: begin
                dec_lit = 1'b1;
                phase_d = PH_CMD;
            end
            PH_POS_LO: begin
                pos_load = 1'b1;
                phase_d  = PH_POS_HI;
            end
            PH_POS_HI: begin
                dec_copy = 1'b1;
                phase_d  = PH_CMD;
            end
        endcase
    end

    assign take_lit  = in_acc && !ignore && dec_lit;
    assign take_copy = in_acc && !ignore && dec_copy;
    assign take_pos  = in_acc && !ignore && pos_load;

    // Limit check for the byte being emitted
    assign bytes_inc = r_bytes + lzwd_pkg::CNT_W'(1);
    assign hit       = (r_limit != '0) && (bytes_inc >= r_limit);

    // An entry counts as written if it lies within the fill run from the start
    assign rd_offset  = r_rd_pos - lzwd_pkg::WRITE_START;
    assign rd_written = ({1'b0, rd_offset} < r_fill);
    assign rd_bypass  = i_cmd.emit && (r_rd_pos == r_wr_pos);

    // Control and counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= '0;
            r_wr_pos    <= lzwd_pkg::WRITE_START;
            r_fill      <= '0;
            r_bytes     <= '0;
            r_flags     <= 16'h0000;
            r_phase     <= PH_CMD;
            r_finished  <= 1'b0;
            r_item_last <= 1'b0;
            r_a_vld     <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_limit <= i_cfg.data.output_length;
            end

            if (in_acc) begin
                if (i_in.data.first_of_stream) begin
                    r_wr_pos <= lzwd_pkg::WRITE_START;
                    r_fill   <= '0;
                    r_bytes  <= '0;
                    r_flags  <= 16'h0000;
                    r_phase  <= PH_CMD;
                end
                r_item_last <= i_in.data.last_input;
                if (ignore) begin
                    r_finished <= 1'b1;
                end else begin
                    r_flags    <= flags_d;
                    r_phase    <= phase_d;
                    r_finished <= i_in.data.last_input;
                end
            end

            // advance write position and counts on every emitted byte
            if (i_cmd.emit) begin
                r_wr_pos <= r_wr_pos + lzwd_pkg::POS_W'(1);
                if (!r_fill[lzwd_pkg::FILL_W-1]) begin
                    r_fill <= r_fill + lzwd_pkg::FILL_W'(1);
                end
                r_bytes <= bytes_inc;
                if (hit) begin
                    r_finished <= 1'b1;
                end
            end

            if (take_lit || i_cmd.issue_read) begin
                r_a_vld <= 1'b1;
            end else if (i_cmd.emit) begin
                r_a_vld <= 1'b0;
            end

            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Command payload registers
    always_ff @(posedge i_clk) begin
        if (take_pos) begin
            r_pos_lo <= in_byte;
        end
        if (take_copy) begin
            r_rd_pos <= {in_byte[7:4], r_pos_lo};
        end else if (i_cmd.issue_read) begin
            r_rd_pos <= r_rd_pos + lzwd_pkg::POS_W'(1);
        end
    end

    // Window write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_window[r_wr_pos] <= r_a_byte;
        end
    end

    // Staging byte: literal, or registered window read with same-cycle forwarding
    always_ff @(posedge i_clk) begin
        if (take_lit) begin
            r_a_byte <= in_byte;
        end else if (i_cmd.issue_read) begin
            if (rd_bypass) begin
                r_a_byte <= r_a_byte;
            end else if (rd_written) begin
                r_a_byte <= r_window[r_rd_pos];
            end else begin
                r_a_byte <= lzwd_pkg::FILL_BYTE;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= '{
                out_byte:    r_a_byte,
                last_of_run: i_cmd.last_of_run,
                stream_done: i_cmd.last_of_run && (hit || r_item_last)
            };
        end
    end

    assign i_in.ready  = i_cmd.take_ok && !r_a_vld;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    assign o_status = '{
        a_vld:      r_a_vld,
        out_free:   !r_out_vld || o_out.ready,
        hit:        hit,
        start_copy: take_copy,
        copy_len:   {1'b0, in_byte[3:0]} + lzwd_pkg::RUN_BIAS
    };

endmodule

/* hw/rtl/lzss_window_decoder.sv */
// LZSS decoder with a 4096-byte ring window; uses lzwd_ctrl and lzwd_datapath.
// A copy of length L (3..18) gives one byte per cycle, unless the output stalls,
// from the window's single registered read port. A literal goes through the
// staging byte and output registers; a copy command first loads the read position
// and run counters. Reset is synchronous; no clearing pass: unwritten window
// entries read as 0xFF through a fill count, so requests flow at once.
`timescale 1ns / 1ps

module lzss_window_decoder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lzwd_stream_if.sink   i_in,
    lzwd_stream_if.source o_out,
    lzwd_stream_if.sink   i_cfg
);

    lzwd_pkg::t_ctrl_cmd  cmd;
    lzwd_pkg::t_dp_status status;

    // Run sequencing
    lzwd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Window, decode and output staging
    lzwd_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_out    (o_out),
        .i_cfg    (i_cfg),
        .i_cmd    (cmd),
        .o_status (status)
    );

endmodule

/* hw/rtl/lzwd_checker.sv */
// Port-level checks for the LZSS window decoder, bound to its top level.
// Depends on lzss_window_decoder and lzwd_stream_if.
`timescale 1ns / 1ps

module lzwd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last_of_run,
    input logic       i_out_stream_done,
    input logic       i_cfg_ready
);

    // Output register empties on reset
    a_reset_clears_out: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // End of stream only ever marks the final byte of a run
    a_done_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_stream_done) |-> i_out_last_of_run)
        else $error("stream_done without last_of_run");

    // Register writes are never back-pressured
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("configuration port stalled");

    // Hold a stalled output request
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid
            && $stable(i_out_byte) && $stable(i_out_last_of_run)
            && $stable(i_out_stream_done)))
        else $error("stalled output request changed");

endmodule

bind lzss_window_decoder lzwd_checker u_lzwd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_byte        (o_out.data.out_byte),
    .i_out_last_of_run (o_out.data.last_of_run),
    .i_out_stream_done (o_out.data.stream_done),
    .i_cfg_ready       (i_cfg.ready)
);
